// ===== hw/rtl/cor_pkg.sv =====
// ----------------------------------------------------------------------------
// cor_pkg
// Shared widths, register codes and request/result types of the circle
// overlap resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package cor_pkg;

  localparam int COORD_BITS    = 20;
  localparam int RADIUS_BITS   = 16;
  localparam int DIST_BITS     = RADIUS_BITS + 1;
  localparam int SQ_BITS       = 2 * RADIUS_BITS;
  localparam int TOT_BITS      = SQ_BITS + 1;
  localparam int RADICAND_BITS = 2 * DIST_BITS;
  localparam int EXTRA_BITS    = 8;
  localparam int MOVE_BITS     = DIST_BITS + 7;
  localparam int MASS_NUM_BITS = DIST_BITS + SQ_BITS + EXTRA_BITS - 1;
  localparam int PROD_BITS     = DIST_BITS + MOVE_BITS;
  localparam int DISP_NUM_BITS = PROD_BITS + 2;
  localparam int DISP_DEN_BITS = DIST_BITS + EXTRA_BITS + 1;
  localparam int DISP_QUO_BITS = DIST_BITS;
  localparam int EQUAL_GAIN    = 96;

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam logic [0:0] REG_WEIGHT_MODE = 1'b0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic        [RADIUS_BITS-1:0] first_radius;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic        [RADIUS_BITS-1:0] second_radius;
  } req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] new_first_x;
    logic signed [COORD_BITS-1:0] new_first_y;
    logic signed [COORD_BITS-1:0] new_second_x;
    logic signed [COORD_BITS-1:0] new_second_y;
    logic                         overlapped;
    logic                         clipped;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cor_sqrt.sv =====
// ----------------------------------------------------------------------------
// cor_sqrt
// Pipelined integer square root, one result bit per stage, with a side
// payload and valid bit carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module cor_sqrt #(
  parameter int RAD_W  = cor_pkg::RADICAND_BITS,
  parameter int SIDE_W = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [RAD_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic                      valid_o,
  output logic [RAD_W/2-1:0]        root_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int ROOT_W = RAD_W / 2;

  logic                vld_q  [ROOT_W];
  logic [RAD_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [SIDE_W-1:0]   side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic              vld_in;
    logic [RAD_W-1:0]  rem_in, rem_n;
    logic [ROOT_W-1:0] root_in, root_n;
    logic [SIDE_W-1:0] side_in;
    logic [RAD_W:0]    trial;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      trial  = ((RAD_W+1)'(root_in) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
      rem_n  = rem_in;
      root_n = root_in;
      if ({1'b0, rem_in} >= trial) begin
        rem_n  = rem_in - trial[RAD_W-1:0];
        root_n = root_in | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_n;
        root_q[k] <= root_n;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/cor_div.sv =====
// ----------------------------------------------------------------------------
// cor_div
// Pipelined restoring divider over several lanes, one quotient bit per
// stage, with a shared side payload and valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cor_div #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int QUO_W  = 8,
  parameter int SIDE_W = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [LANES-1:0][NUM_W-1:0] num_i,
  input  wire logic [LANES-1:0][DEN_W-1:0] den_i,
  input  wire logic [SIDE_W-1:0]           side_i,
  output logic                             valid_o,
  output logic      [LANES-1:0][QUO_W-1:0] quo_o,
  output logic      [SIDE_W-1:0]           side_o
);

  logic                        vld_q  [QUO_W];
  logic [LANES-1:0][NUM_W-1:0] rem_q  [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] den_q  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_q  [QUO_W];
  logic [SIDE_W-1:0]           side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic                        vld_in;
    logic [LANES-1:0][NUM_W-1:0] rem_in, rem_n;
    logic [LANES-1:0][DEN_W-1:0] den_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in, quo_n;
    logic [SIDE_W-1:0]           side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      rem_n = rem_in;
      quo_n = quo_in;
      for (int l = 0; l < LANES; l++) begin
        if ((rem_in[l] >> B) >= NUM_W'(den_in[l])) begin
          rem_n[l] = rem_in[l] - (NUM_W'(den_in[l]) << B);
          quo_n[l] = quo_in[l] | (QUO_W'(1) << B);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_n;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_n;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/circle_overlap_resolver_core.sv =====
// ----------------------------------------------------------------------------
// circle_overlap_resolver_core
// Pushes two overlapping circles apart along their center line.
// ----------------------------------------------------------------------------
// A request carries two centers and two radii on the in channel (valid/ready);
// the corrected centers with overlap and saturation flags leave on the out
// channel. weight_mode sits at APB byte address 0 and is sampled per request
// on entry; write it only while the block is empty.
// A request passes through 67 register stages on its way to the out channel.
// Stages: four front stages, a 17-stage square root, two stages, a 24-stage
// mass-ratio divider, two stages, a 17-stage displacement divider and the
// output register.
// Throughput is one request per cycle while the receiver does not stall;
// every stage advances together. When the receiver stalls, the whole pipeline
// holds and in_ready_o drops in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and sets weight_mode to equal split.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_overlap_resolver_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire cor_pkg::req_t                   req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output cor_pkg::rsp_t                        rsp_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cor_pkg::PADDR_BITS-1:0]  paddr,
  input  wire logic [cor_pkg::PDATA_BITS-1:0]  pwdata,
  output logic      [cor_pkg::PDATA_BITS-1:0]  prdata,
  output logic                                 pready
);

  localparam int CW    = cor_pkg::COORD_BITS;
  localparam int RW    = cor_pkg::RADIUS_BITS;
  localparam int DW    = cor_pkg::DIST_BITS;
  localparam int SQW   = cor_pkg::SQ_BITS;
  localparam int TW    = cor_pkg::TOT_BITS;
  localparam int RADW  = cor_pkg::RADICAND_BITS;
  localparam int MW    = cor_pkg::MOVE_BITS;
  localparam int EB    = cor_pkg::EXTRA_BITS;
  localparam int MNW   = cor_pkg::MASS_NUM_BITS;
  localparam int PW    = cor_pkg::PROD_BITS;
  localparam int DNW   = cor_pkg::DISP_NUM_BITS;
  localparam int DDW   = cor_pkg::DISP_DEN_BITS;
  localparam int DQW   = cor_pkg::DISP_QUO_BITS;
  localparam int CMP_W = (CW + 1 > DW) ? CW + 1 : DW;
  localparam int SUM_W = ((CW > DQW) ? CW : DQW) + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic                 neg_x;
    logic                 neg_y;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic [DW-1:0]        ssum;
    logic [SQW-1:0]       sq1;
    logic [SQW-1:0]       sq2;
    logic [TW-1:0]        tot;
    logic [DW-1:0]        span;
    logic [MW-1:0]        meq;
    logic                 hit;
    logic                 mode;
  } ctx_t;

  localparam int CTX_W = $bits(ctx_t);

  // configuration
  logic weight_mode_q;
  logic cfg_sel;

  assign cfg_sel = (paddr[cor_pkg::PADDR_BITS-1:2] == cor_pkg::REG_WEIGHT_MODE);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? {{(cor_pkg::PDATA_BITS-1){1'b0}}, weight_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && cfg_sel) begin
      weight_mode_q <= pwdata[0];
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage A: differences and radius sum
  logic                 a_vld_q;
  ctx_t                 a_ctx_q, a_ctx_d;
  logic signed [CW:0]   a_dx_q, a_dy_q;
  logic [RW-1:0]        a_r1_q, a_r2_q;

  always_comb begin
    a_ctx_d       = '0;
    a_ctx_d.x1    = req_i.first_x;
    a_ctx_d.y1    = req_i.first_y;
    a_ctx_d.x2    = req_i.second_x;
    a_ctx_d.y2    = req_i.second_y;
    a_ctx_d.ssum  = DW'(req_i.first_radius) + DW'(req_i.second_radius);
    a_ctx_d.mode  = weight_mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ctx_q <= a_ctx_d;
      a_dx_q  <= {req_i.first_x[CW-1], req_i.first_x} - {req_i.second_x[CW-1], req_i.second_x};
      a_dy_q  <= {req_i.first_y[CW-1], req_i.first_y} - {req_i.second_y[CW-1], req_i.second_y};
      a_r1_q  <= req_i.first_radius;
      a_r2_q  <= req_i.second_radius;
    end
  end

  // stage B: magnitudes and box test
  logic          b_vld_q, b_cand_q;
  ctx_t          b_ctx_q, b_ctx_d;
  logic [RW-1:0] b_r1_q, b_r2_q;
  logic [CW:0]   adx_w, ady_w;
  logic          cand_w;

  always_comb begin
    adx_w         = a_dx_q[CW] ? (CW+1)'(0) - a_dx_q : a_dx_q;
    ady_w         = a_dy_q[CW] ? (CW+1)'(0) - a_dy_q : a_dy_q;
    cand_w        = (a_ctx_q.ssum != '0) && (CMP_W'(adx_w) < CMP_W'(a_ctx_q.ssum))
                    && (CMP_W'(ady_w) < CMP_W'(a_ctx_q.ssum));
    b_ctx_d       = a_ctx_q;
    b_ctx_d.neg_x = a_dx_q[CW];
    b_ctx_d.neg_y = a_dy_q[CW];
    b_ctx_d.adx   = adx_w[DW-1:0];
    b_ctx_d.ady   = ady_w[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_ctx_q  <= b_ctx_d;
      b_cand_q <= cand_w;
      b_r1_q   <= a_r1_q;
      b_r2_q   <= a_r2_q;
    end
  end

  // stage C: squares
  logic            c_vld_q, c_cand_q;
  ctx_t            c_ctx_q, c_ctx_d;
  logic [RADW-1:0] c_adx2_q, c_ady2_q, c_s2_q;

  always_comb begin
    c_ctx_d     = b_ctx_q;
    c_ctx_d.sq1 = SQW'(b_r1_q) * SQW'(b_r1_q);
    c_ctx_d.sq2 = SQW'(b_r2_q) * SQW'(b_r2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_ctx_q  <= c_ctx_d;
      c_cand_q <= b_cand_q;
      c_adx2_q <= RADW'(b_ctx_q.adx) * RADW'(b_ctx_q.adx);
      c_ady2_q <= RADW'(b_ctx_q.ady) * RADW'(b_ctx_q.ady);
      c_s2_q   <= RADW'(b_ctx_q.ssum) * RADW'(b_ctx_q.ssum);
    end
  end

  // stage D: distance squared and overlap test
  logic            d_vld_q;
  ctx_t            d_ctx_q, d_ctx_d;
  logic [RADW-1:0] d_rad_q;
  logic [RADW:0]   d2_w;

  always_comb begin
    d2_w        = (RADW+1)'(c_adx2_q) + (RADW+1)'(c_ady2_q);
    d_ctx_d     = c_ctx_q;
    d_ctx_d.tot = TW'(c_ctx_q.sq1) + TW'(c_ctx_q.sq2);
    d_ctx_d.hit = c_cand_q && (d2_w != '0) && (d2_w < (RADW+1)'(c_s2_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ctx_q <= d_ctx_d;
      d_rad_q <= d2_w[RADW-1:0];
    end
  end

  // square root
  logic          q_vld;
  logic [DW-1:0] q_root;
  ctx_t          q_ctx;

  cor_sqrt #(
    .RAD_W  (RADW),
    .SIDE_W (CTX_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld_q),
    .rad_i   (d_rad_q),
    .side_i  (d_ctx_q),
    .valid_o (q_vld),
    .root_o  (q_root),
    .side_o  (q_ctx)
  );

  // stage E: overlap and equal-split move
  logic          e_vld_q;
  ctx_t          e_ctx_q, e_ctx_d;
  logic [DW-1:0] e_ov_q, ov_w;

  always_comb begin
    ov_w         = q_ctx.ssum - q_root;
    e_ctx_d      = q_ctx;
    e_ctx_d.span = q_root;
    e_ctx_d.meq  = MW'(ov_w) * MW'(cor_pkg::EQUAL_GAIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ctx_q <= e_ctx_d;
      e_ov_q  <= ov_w;
    end
  end

  // stage F: mass-split numerators
  localparam int MPW = DW + SQW;
  logic           f_vld_q;
  ctx_t           f_ctx_q;
  logic [MPW-1:0] f_p1_q, f_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_ctx_q <= e_ctx_q;
      f_p1_q  <= MPW'(e_ov_q) * MPW'(e_ctx_q.sq2);
      f_p2_q  <= MPW'(e_ov_q) * MPW'(e_ctx_q.sq1);
    end
  end

  // mass-ratio divider
  logic [1:0][MNW-1:0] mnum;
  logic [1:0][TW-1:0]  mden;
  logic [1:0][MW-1:0]  m_quo;
  logic                m_vld;
  ctx_t                m_ctx;

  assign mnum[0] = {f_p1_q, (EB-1)'(0)};
  assign mnum[1] = {f_p2_q, (EB-1)'(0)};
  assign mden[0] = f_ctx_q.tot;
  assign mden[1] = f_ctx_q.tot;

  cor_div #(
    .LANES  (2),
    .NUM_W  (MNW),
    .DEN_W  (TW),
    .QUO_W  (MW),
    .SIDE_W (CTX_W)
  ) u_mass_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld_q),
    .num_i   (mnum),
    .den_i   (mden),
    .side_i  (f_ctx_q),
    .valid_o (m_vld),
    .quo_o   (m_quo),
    .side_o  (m_ctx)
  );

  // stage G: axis products
  logic              g_vld_q;
  ctx_t              g_ctx_q;
  logic [3:0][PW-1:0] g_p_q;
  logic [MW-1:0]     m1_w, m2_w;

  assign m1_w = m_ctx.mode ? m_quo[0] : m_ctx.meq;
  assign m2_w = m_ctx.mode ? m_quo[1] : m_ctx.meq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= m_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_ctx_q  <= m_ctx;
      g_p_q[0] <= PW'(m_ctx.adx) * PW'(m1_w);
      g_p_q[1] <= PW'(m_ctx.ady) * PW'(m1_w);
      g_p_q[2] <= PW'(m_ctx.adx) * PW'(m2_w);
      g_p_q[3] <= PW'(m_ctx.ady) * PW'(m2_w);
    end
  end

  // stage H: rounding numerators
  logic               h_vld_q;
  ctx_t               h_ctx_q;
  logic [3:0][DNW-1:0] h_num_q, h_num_d;
  logic [3:0][DDW-1:0] h_den_q, h_den_d;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      h_num_d[l] = {1'b0, g_p_q[l], 1'b0} + DNW'({g_ctx_q.span, EB'(0)});
      h_den_d[l] = {g_ctx_q.span, (EB+1)'(0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (en) begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_ctx_q <= g_ctx_q;
      h_num_q <= h_num_d;
      h_den_q <= h_den_d;
    end
  end

  // displacement divider
  logic [3:0][DQW-1:0] k_quo;
  logic                k_vld;
  ctx_t                k_ctx;

  cor_div #(
    .LANES  (4),
    .NUM_W  (DNW),
    .DEN_W  (DDW),
    .QUO_W  (DQW),
    .SIDE_W (CTX_W)
  ) u_disp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_vld_q),
    .num_i   (h_num_q),
    .den_i   (h_den_q),
    .side_i  (h_ctx_q),
    .valid_o (k_vld),
    .quo_o   (k_quo),
    .side_o  (k_ctx)
  );

  // output stage: apply, saturate
  logic signed [CW-1:0]    base_w [4];
  logic signed [SUM_W-1:0] step_w [4];
  logic signed [SUM_W-1:0] sum_w  [4];
  logic signed [CW-1:0]    res_w  [4];
  logic [3:0]              clip_w;
  logic                    neg_w  [4];
  cor_pkg::rsp_t           rsp_d, rsp_q;

  always_comb begin
    base_w[0] = k_ctx.x1;
    base_w[1] = k_ctx.y1;
    base_w[2] = k_ctx.x2;
    base_w[3] = k_ctx.y2;
    neg_w[0]  = k_ctx.neg_x;
    neg_w[1]  = k_ctx.neg_y;
    neg_w[2]  = k_ctx.neg_x;
    neg_w[3]  = k_ctx.neg_y;
    for (int l = 0; l < 4; l++) begin
      step_w[l] = $signed({{(SUM_W-DQW){1'b0}}, k_quo[l]});
      if (neg_w[l]) begin
        step_w[l] = -step_w[l];
      end
      if (!k_ctx.hit) begin
        step_w[l] = '0;
      end
      if (l < 2) begin
        sum_w[l] = {{(SUM_W-CW){base_w[l][CW-1]}}, base_w[l]} + step_w[l];
      end else begin
        sum_w[l] = {{(SUM_W-CW){base_w[l][CW-1]}}, base_w[l]} - step_w[l];
      end
      clip_w[l] = 1'b0;
      res_w[l]  = sum_w[l][CW-1:0];
      if (sum_w[l] > SAT_HI) begin
        res_w[l]  = SAT_HI[CW-1:0];
        clip_w[l] = 1'b1;
      end else if (sum_w[l] < SAT_LO) begin
        res_w[l]  = SAT_LO[CW-1:0];
        clip_w[l] = 1'b1;
      end
    end
    rsp_d.new_first_x  = res_w[0];
    rsp_d.new_first_y  = res_w[1];
    rsp_d.new_second_x = res_w[2];
    rsp_d.new_second_y = res_w[3];
    rsp_d.overlapped   = k_ctx.hit;
    rsp_d.clipped      = |clip_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= k_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  a_clip_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rsp_o.overlapped |-> !rsp_o.clipped)
    else $error("clipped result without overlap");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while output stalled");

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> a_vld_q)
    else $error("accepted request missing from first stage");

endmodule

`default_nettype wire
